/* hdl/wrcp_pkg.sv */
// ----------------------------------------------------------------------------
// WAVE chunk parser package
// Shared types, chunk identifiers, fault codes and helpers for the parser.
// ----------------------------------------------------------------------------
package wrcp_pkg;

  // Little-endian four-character codes as they appear after four byte shifts.
  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM      = 16'h0001;
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

  // Reset values of the configuration registers.
  localparam logic [15:0] RESET_CHANNELS = 16'd2;
  localparam logic [31:0] RESET_RATE     = 32'd48000;
  localparam logic [15:0] RESET_BITS     = 16'd16;

  // Configuration register indexes.
  localparam logic [1:0] REG_CHANNELS = 2'd0;
  localparam logic [1:0] REG_RATE     = 2'd1;
  localparam logic [1:0] REG_BITS     = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_FAULT   = 2'd2;

  // Fault codes.
  localparam logic [3:0] FAULT_NONE      = 4'd0;
  localparam logic [3:0] FAULT_RIFF      = 4'd1;
  localparam logic [3:0] FAULT_WAVE      = 4'd2;
  localparam logic [3:0] FAULT_NOT_PCM   = 4'd3;
  localparam logic [3:0] FAULT_CHANNELS  = 4'd4;
  localparam logic [3:0] FAULT_RATE      = 4'd5;
  localparam logic [3:0] FAULT_BITS      = 4'd6;
  localparam logic [3:0] FAULT_ALIGN     = 4'd7;
  localparam logic [3:0] FAULT_SHORT_FMT = 4'd8;

  typedef enum logic [2:0] {
    PH_FILE_HDR  = 3'd0,
    PH_CHUNK_HDR = 3'd1,
    PH_FMT       = 3'd2,
    PH_DATA      = 3'd3,
    PH_SKIP      = 3'd4,
    PH_HALT      = 3'd5
  } phase_e;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_e      phase;
    logic [31:0] file_offset;
    logic [31:0] byte_count;
    logic [31:0] id_shift;
    logic [31:0] size_value;
    logic [31:0] fmt_shift;
    logic [15:0] channels_seen;
    logic [3:0]  fault;
    logic [31:0] data_start;
    logic [31:0] data_size;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:         PH_FILE_HDR,
    file_offset:   32'd0,
    byte_count:    32'd0,
    id_shift:      32'd0,
    size_value:    32'd0,
    fmt_shift:     32'd0,
    channels_seen: 16'd0,
    fault:         FAULT_NONE,
    data_start:    32'd0,
    data_size:     32'd0
  };

  typedef struct packed {
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] bits;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  payload_byte;
    logic [3:0]  fault_code;
    logic [31:0] data_offset;
    logic [31:0] data_length;
    logic        stream_done;
  } result_t;

  // Little-endian shift: the new byte enters at the top.
  function automatic logic [31:0] shift_in(input logic [31:0] word, input logic [7:0] b);
    shift_in = {b, word[31:8]};
  endfunction

endpackage

/* hdl/wrcp_if.sv */
// ----------------------------------------------------------------------------
// WAVE chunk parser channel interfaces
// Valid/ready channels for file bytes, results and register writes.
// ----------------------------------------------------------------------------

// File byte channel.
interface wrcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       last_byte;

  modport source (output valid, output file_byte, output last_byte, input ready);
  modport sink   (input valid, input file_byte, input last_byte, output ready);
endinterface

// Result channel.
interface wrcp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  payload_byte;
  logic [3:0]  fault_code;
  logic [31:0] data_offset;
  logic [31:0] data_length;
  logic        stream_done;

  modport source (output valid, output event_kind, output payload_byte, output fault_code,
                  output data_offset, output data_length, output stream_done, input ready);
  modport sink   (input valid, input event_kind, input payload_byte, input fault_code,
                  input data_offset, input data_length, input stream_done, output ready);
endinterface

// Register write channel.
interface wrcp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/wrcp_step.sv */
// ----------------------------------------------------------------------------
// WAVE chunk parser step logic
// Next parser state and the result for one file byte.
// ----------------------------------------------------------------------------
module wrcp_step (
  input  wrcp_pkg::state_t  state_i,
  input  wrcp_pkg::cfg_t    cfg_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output wrcp_pkg::state_t  state_o,
  output wrcp_pkg::result_t result_o
);
  import wrcp_pkg::*;

  state_t      nxt;
  logic [3:0]  fmt_fault;
  logic [31:0] count_inc;

  assign count_inc = state_i.byte_count + 32'd1;

  always_comb begin
    nxt       = state_i;
    fmt_fault = FAULT_NONE;
    result_o  = '0;
    result_o.event_kind = KIND_HEADER;

    unique case (state_i.phase) inside
      // RIFF at bytes 0..3, size ignored, WAVE at bytes 8..11.
      PH_FILE_HDR: begin
        nxt.id_shift = shift_in(state_i.id_shift, byte_i);
        if (state_i.byte_count == 32'd3 && nxt.id_shift != ID_RIFF) begin
          nxt.fault = FAULT_RIFF;
          nxt.phase = PH_HALT;
        end else if (state_i.byte_count == 32'd11) begin
          if (nxt.id_shift != ID_WAVE) begin
            nxt.fault = FAULT_WAVE;
            nxt.phase = PH_HALT;
          end else begin
            nxt.phase      = PH_CHUNK_HDR;
            nxt.byte_count = 32'd0;
          end
        end else begin
          nxt.byte_count = count_inc;
        end
      end

      // Chunk id then size; on the eighth byte choose how to treat the body.
      PH_CHUNK_HDR: begin
        if (state_i.byte_count < 32'd4) begin
          nxt.id_shift = shift_in(state_i.id_shift, byte_i);
        end else begin
          nxt.size_value = shift_in(state_i.size_value, byte_i);
        end
        if (state_i.byte_count == 32'd7) begin
          nxt.byte_count = 32'd0;
          if (nxt.id_shift == ID_FMT) begin
            if (nxt.size_value < FMT_MIN_SIZE) begin
              nxt.fault = FAULT_SHORT_FMT;
              nxt.phase = PH_HALT;
            end else begin
              nxt.phase = PH_FMT;
            end
          end else if (nxt.id_shift == ID_DATA) begin
            nxt.data_start = state_i.file_offset + 32'd1;
            nxt.data_size  = nxt.size_value;
            nxt.phase      = (nxt.size_value != 32'd0) ? PH_DATA : PH_CHUNK_HDR;
          end else begin
            nxt.phase      = (nxt.size_value != 32'd0) ? PH_SKIP : PH_CHUNK_HDR;
          end
        end else begin
          nxt.byte_count = count_inc;
        end
      end

      // Format chunk: fields are checked as their last byte arrives.
      PH_FMT: begin
        nxt.fmt_shift = shift_in(state_i.fmt_shift, byte_i);
        case (state_i.byte_count)
          32'd1: begin
            if (nxt.fmt_shift[31:16] != FMT_PCM) fmt_fault = FAULT_NOT_PCM;
          end
          32'd3: begin
            nxt.channels_seen = nxt.fmt_shift[31:16];
            if (nxt.fmt_shift[31:16] != cfg_i.channels) fmt_fault = FAULT_CHANNELS;
          end
          32'd7: begin
            if (nxt.fmt_shift != cfg_i.rate) fmt_fault = FAULT_RATE;
          end
          32'd15: begin
            if (nxt.fmt_shift[31:16] != cfg_i.bits) begin
              fmt_fault = FAULT_BITS;
            end else if ({1'b0, nxt.fmt_shift[15:0]} != {state_i.channels_seen, 1'b0}) begin
              fmt_fault = FAULT_ALIGN;
            end
          end
          default: ;
        endcase
        if (fmt_fault != FAULT_NONE) begin
          nxt.fault = fmt_fault;
          nxt.phase = PH_HALT;
        end else if (count_inc == state_i.size_value) begin
          nxt.phase      = PH_CHUNK_HDR;
          nxt.byte_count = 32'd0;
        end else begin
          nxt.byte_count = count_inc;
        end
      end

      // Data and skipped bodies count up to the chunk size, then return to the chunk header.
      PH_DATA, PH_SKIP: begin
        if (state_i.phase == PH_DATA) begin
          result_o.event_kind   = KIND_PAYLOAD;
          result_o.payload_byte = byte_i;
        end
        if (count_inc == state_i.size_value) begin
          nxt.phase      = PH_CHUNK_HDR;
          nxt.byte_count = 32'd0;
        end else begin
          nxt.byte_count = count_inc;
        end
      end

      PH_HALT: ;
      default: ;
    endcase

    nxt.file_offset = state_i.file_offset + 32'd1;

    if (nxt.fault != FAULT_NONE) begin
      result_o.event_kind   = KIND_FAULT;
      result_o.payload_byte = 8'd0;
    end
    result_o.fault_code  = nxt.fault;
    result_o.data_offset = nxt.data_start;
    result_o.data_length = nxt.data_size;
    result_o.stream_done = last_i;
  end

  // The last byte of a file returns the parser to its start.
  assign state_o = last_i ? STATE_RESET : nxt;

endmodule

/* hdl/wave_riff_chunk_parser_core.sv */
// ----------------------------------------------------------------------------
// WAVE chunk parser core
// Parses a WAVE file byte stream, checks the format chunk, emits audio bytes.
// ----------------------------------------------------------------------------
// The parser takes one file byte per clock cycle and gives exactly one result
// per byte, held in an output register. A new byte is taken in
// every cycle in which the output register is empty or its result is being
// transferred, so a steady stream runs at one byte per cycle; the figure is set
// by the single state update per byte between the parser state registers and
// the result register. Register writes are always taken and must come while
// no byte is in flight. The parser needs no start-up time after reset.
module wave_riff_chunk_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  wrcp_in_if.sink    in_if,
  wrcp_out_if.source out_if,
  wrcp_cfg_if.sink   cfg_if
);
  import wrcp_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  result_t result_q;
  result_t result_d;
  logic    out_valid_q;
  logic    in_xfer;

  // A byte is taken when the result register is free or drains this cycle.
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_xfer     = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  wrcp_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .byte_i   (in_if.file_byte),
    .last_i   (in_if.last_byte),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channels <= RESET_CHANNELS;
      cfg_q.rate     <= RESET_RATE;
      cfg_q.bits     <= RESET_BITS;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_CHANNELS: cfg_q.channels <= cfg_if.data[15:0];
        REG_RATE:     cfg_q.rate     <= cfg_if.data;
        REG_BITS:     cfg_q.bits     <= cfg_if.data[15:0];
        default: ;
      endcase
    end
  end

  // Parser state advances on every byte transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      result_q <= result_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.event_kind   = result_q.event_kind;
  assign out_if.payload_byte = result_q.payload_byte;
  assign out_if.fault_code   = result_q.fault_code;
  assign out_if.data_offset  = result_q.data_offset;
  assign out_if.data_length  = result_q.data_length;
  assign out_if.stream_done  = result_q.stream_done;

endmodule

/* tb/sv/tb_wave_riff_chunk_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAVE chunk parser testbench
// Feeds generated WAVE files byte by byte, mostly well formed with random
// content and some corrupted, truncated or noise files. A local parser model
// predicts one result per byte, and a monitor compares each result transfer
// against the oldest prediction. Phases change the register settings and the
// amount of source idling and sink stalling.
// ----------------------------------------------------------------------------
module tb_wave_riff_chunk_parser_core;
  import wrcp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          NUM_PHASES   = 8;
  localparam int          PHASE_BUDGET = 100;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } stream_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wrcp_in_if  in_bus ();
  wrcp_out_if out_bus ();
  wrcp_cfg_if cfg_bus ();

  wave_riff_chunk_parser_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  // Stimulus and prediction state.
  stream_byte_t file_bytes_q[$];
  stream_byte_t held_byte;
  bit           byte_held;
  logic [7:0]   file_buf[$];
  result_t      expected_results[$];
  state_t       parser_st;
  cfg_t         model_cfg;
  int           src_idle_pct;
  int           sink_stall_pct;
  bit           calm;
  int           fail_count;
  int unsigned  cycles;

  always #1 clk_i = ~clk_i;

  // Parser model.
  function automatic void latch_fault(input logic [3:0] code);
    if (parser_st.fault == FAULT_NONE) begin
      parser_st.fault = code;
      parser_st.phase = PH_HALT;
    end
  endfunction

  // One body byte consumed; the last one leads to the next chunk header.
  function automatic void advance_body();
    if (parser_st.byte_count + 32'd1 == parser_st.size_value) begin
      parser_st.phase      = PH_CHUNK_HDR;
      parser_st.byte_count = 32'd0;
    end else begin
      parser_st.byte_count = parser_st.byte_count + 32'd1;
    end
  endfunction

  function automatic result_t parse_file_byte(input logic [7:0] b, input logic last);
    result_t r;
    r.event_kind   = KIND_HEADER;
    r.payload_byte = 8'd0;
    case (parser_st.phase)
      PH_FILE_HDR: begin
        parser_st.id_shift = {b, parser_st.id_shift[31:8]};
        if (parser_st.byte_count == 32'd3 && parser_st.id_shift != ID_RIFF) begin
          latch_fault(FAULT_RIFF);
        end else if (parser_st.byte_count == 32'd11) begin
          if (parser_st.id_shift != ID_WAVE) begin
            latch_fault(FAULT_WAVE);
          end else begin
            parser_st.phase      = PH_CHUNK_HDR;
            parser_st.byte_count = 32'd0;
          end
        end else begin
          parser_st.byte_count = parser_st.byte_count + 32'd1;
        end
      end
      PH_CHUNK_HDR: begin
        if (parser_st.byte_count < 32'd4) begin
          parser_st.id_shift = {b, parser_st.id_shift[31:8]};
        end else begin
          parser_st.size_value = {b, parser_st.size_value[31:8]};
        end
        if (parser_st.byte_count != 32'd7) begin
          parser_st.byte_count = parser_st.byte_count + 32'd1;
        end else begin
          // Header complete: decide how the body is handled.
          parser_st.byte_count = 32'd0;
          if (parser_st.id_shift == ID_FMT) begin
            if (parser_st.size_value < FMT_MIN_SIZE) latch_fault(FAULT_SHORT_FMT);
            else parser_st.phase = PH_FMT;
          end else if (parser_st.id_shift == ID_DATA) begin
            parser_st.data_start = parser_st.file_offset + 32'd1;
            parser_st.data_size  = parser_st.size_value;
            parser_st.phase = (parser_st.size_value != 32'd0) ? PH_DATA : PH_CHUNK_HDR;
          end else begin
            parser_st.phase = (parser_st.size_value != 32'd0) ? PH_SKIP : PH_CHUNK_HDR;
          end
        end
      end
      PH_FMT: begin
        parser_st.fmt_shift = {b, parser_st.fmt_shift[31:8]};
        case (parser_st.byte_count)
          32'd1: begin
            if (parser_st.fmt_shift[31:16] != FMT_PCM) latch_fault(FAULT_NOT_PCM);
          end
          32'd3: begin
            parser_st.channels_seen = parser_st.fmt_shift[31:16];
            if (parser_st.channels_seen != model_cfg.channels) latch_fault(FAULT_CHANNELS);
          end
          32'd7: begin
            if (parser_st.fmt_shift != model_cfg.rate) latch_fault(FAULT_RATE);
          end
          32'd15: begin
            // Bits per sample first, then block align against twice the channels.
            if (parser_st.fmt_shift[31:16] != model_cfg.bits) begin
              latch_fault(FAULT_BITS);
            end else if ({16'd0, parser_st.fmt_shift[15:0]} !=
                         {15'd0, parser_st.channels_seen, 1'b0}) begin
              latch_fault(FAULT_ALIGN);
            end
          end
          default: ;
        endcase
        if (parser_st.fault == FAULT_NONE) advance_body();
      end
      PH_DATA: begin
        r.event_kind   = KIND_PAYLOAD;
        r.payload_byte = b;
        advance_body();
      end
      PH_SKIP: begin
        advance_body();
      end
      default: ;
    endcase
    parser_st.file_offset = parser_st.file_offset + 32'd1;

    if (parser_st.fault != FAULT_NONE) begin
      r.event_kind   = KIND_FAULT;
      r.payload_byte = 8'd0;
    end
    r.fault_code  = parser_st.fault;
    r.data_offset = parser_st.data_start;
    r.data_length = parser_st.data_size;
    r.stream_done = last;
    if (last) parser_st = STATE_RESET;
    return r;
  endfunction

  // File building helpers.
  task automatic put_le16(input logic [15:0] v);
    file_buf.push_back(v[7:0]);
    file_buf.push_back(v[15:8]);
  endtask

  task automatic put_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_buf.push_back(v[8*i +: 8]);
  endtask

  task automatic put_random(input int n);
    for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Queue the built file, flagging its final byte.
  task automatic emit_file();
    stream_byte_t item;
    for (int i = 0; i < file_buf.size(); i++) begin
      item.value = file_buf[i];
      item.last  = (i == file_buf.size() - 1);
      file_bytes_q.push_back(item);
    end
  endtask

  // A WAVE file that mostly matches the current settings, with the
  // occasional bad field, flipped bit or early end.
  task automatic build_wave_file();
    int          n_chunks;
    int          pick;
    int          len;
    int          idx;
    int          cut;
    bit          open_ended;
    logic [15:0] tag;
    logic [15:0] ch;
    logic [15:0] bits;
    logic [15:0] align;
    logic [31:0] rate;
    logic [31:0] size;
    file_buf.delete();
    open_ended = 1'b0;
    put_le32(ID_RIFF);
    put_le32($urandom());
    put_le32(ID_WAVE);
    n_chunks = $urandom_range(1, 4);
    for (int c = 0; c < n_chunks && !open_ended; c++) begin
      pick = (c == 0 && $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 4);
      case (pick) inside
        0: begin
          case ($urandom_range(0, 7)) inside
            0:       len = $urandom_range(0, 15);
            1, 2:    len = 16 + $urandom_range(1, 6);
            default: len = 16;
          endcase
          put_le32(ID_FMT);
          put_le32(len);
          if (len < 16) begin
            put_random(len);
          end else begin
            tag   = FMT_PCM;
            ch    = model_cfg.channels;
            rate  = model_cfg.rate;
            bits  = model_cfg.bits;
            align = {ch[14:0], 1'b0};
            case ($urandom_range(0, 11))
              0:       tag = 16'($urandom_range(0, 65535));
              1:       ch = ch ^ (16'd1 << $urandom_range(0, 15));
              2:       rate = rate ^ (32'd1 << $urandom_range(0, 31));
              3:       bits = bits ^ (16'd1 << $urandom_range(0, 15));
              4:       align = align ^ (16'd1 << $urandom_range(0, 15));
              default: ;
            endcase
            put_le16(tag);
            put_le16(ch);
            put_le32(rate);
            put_le32($urandom());
            put_le16(align);
            put_le16(bits);
            put_random(len - 16);
          end
        end
        1, 2: begin
          case ($urandom_range(0, 15))
            0:       size = 32'd0;
            1: begin
              // Huge declared size: the file ends inside the payload.
              size       = $urandom() | 32'h8000_0000;
              open_ended = 1'b1;
            end
            default: size = $urandom_range(1, 12);
          endcase
          put_le32(ID_DATA);
          put_le32(size);
          put_random(open_ended ? $urandom_range(0, 10) : int'(size));
        end
        default: begin
          size = $urandom_range(0, 8);
          put_le32($urandom());
          put_le32(size);
          put_random(size);
        end
      endcase
    end
    if ($urandom_range(0, 7) == 0) begin
      idx = $urandom_range(0, file_buf.size() - 1);
      file_buf[idx] = file_buf[idx] ^ (8'd1 << $urandom_range(0, 7));
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, file_buf.size());
      while (file_buf.size() > cut) void'(file_buf.pop_back());
    end
  endtask

  // Configuration write; the model copy follows on the accepting edge.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      REG_CHANNELS: model_cfg.channels = value[15:0];
      REG_RATE:     model_cfg.rate     = value;
      REG_BITS:     model_cfg.bits     = value[15:0];
      default:      ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0s: expected kind %0d byte %02h fault %0d offset %08h length %08h done %0b",
               what, want.event_kind, want.payload_byte, want.fault_code,
               want.data_offset, want.data_length, want.stream_done);
      $display("  actual kind %0d byte %02h fault %0d offset %08h length %08h done %0b",
               got.event_kind, got.payload_byte, got.fault_code,
               got.data_offset, got.data_length, got.stream_done);
    end
  endtask

  // Byte driver: presents the next queued byte and holds it until its transfer.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 47) == 0) calm = !calm;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!byte_held) begin
      if (file_bytes_q.size() != 0 && (calm || $urandom_range(0, 99) >= src_idle_pct)) begin
        held_byte = file_bytes_q.pop_front();
        byte_held = 1'b1;
        in_bus.valid     <= 1'b1;
        in_bus.file_byte <= held_byte.value;
        in_bus.last_byte <= held_byte.last;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Byte transfer: predict its result.
  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      expected_results.push_back(parse_file_byte(held_byte.value, held_byte.last));
      byte_held = 1'b0;
    end
  end

  // Result sink stalls.
  always @(negedge clk_i) begin
    if (!rst_ni) out_bus.ready <= 1'b0;
    else out_bus.ready <= calm || ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Result monitor and run limit.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.event_kind   = out_bus.event_kind;
      got.payload_byte = out_bus.payload_byte;
      got.fault_code   = out_bus.fault_code;
      got.data_offset  = out_bus.data_offset;
      got.data_length  = out_bus.data_length;
      got.stream_done  = out_bus.stream_done;
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
      end
    end
  end

  // Test sequence.
  initial begin
    int queued;
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.file_byte  = 8'd0;
    in_bus.last_byte  = 1'b0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = REG_CHANNELS;
    cfg_bus.data      = 32'd0;
    byte_held         = 1'b0;
    calm              = 1'b0;
    fail_count        = 0;
    cycles            = 0;
    src_idle_pct      = 0;
    sink_stall_pct    = 0;
    parser_st         = STATE_RESET;
    model_cfg         = '{channels: RESET_CHANNELS, rate: RESET_RATE, bits: RESET_BITS};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 79; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 79; end
        default: begin src_idle_pct = 28; sink_stall_pct = 28; end
      endcase

      // Register settings: reset values, both extremes, then random ones.
      case (phase)
        0: begin
          write_reg(REG_CHANNELS, {16'd0, RESET_CHANNELS});
          write_reg(REG_RATE, RESET_RATE);
          write_reg(REG_BITS, {16'd0, RESET_BITS});
        end
        1: begin
          write_reg(REG_CHANNELS, 32'd1);
          write_reg(REG_RATE, 32'd1);
          write_reg(REG_BITS, 32'd1);
        end
        2: begin
          write_reg(REG_CHANNELS, 32'd65535);
          write_reg(REG_RATE, 32'hFFFF_FFFF);
          write_reg(REG_BITS, 32'd65535);
        end
        default: begin
          write_reg(REG_CHANNELS, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                              : $urandom_range(1, 8));
          case ($urandom_range(0, 4))
            0:       write_reg(REG_RATE, 32'd44100);
            1:       write_reg(REG_RATE, 32'd96000);
            2:       write_reg(REG_RATE, 32'd8000);
            default: write_reg(REG_RATE, $urandom() | 32'd1);
          endcase
          write_reg(REG_BITS, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 65535)
                                                          : 8 * $urandom_range(1, 4));
        end
      endcase
      @(negedge clk_i);
      cfg_bus.valid <= 1'b0;

      if (phase == 0) begin
        // One-byte file at the top byte value.
        file_buf.delete();
        file_buf.push_back(8'hFF);
        emit_file();
        // Wrong RIFF identifier, ended right at the check.
        file_buf.delete();
        put_le32(ID_RIFF ^ 32'h0100_0000);
        emit_file();
        // Good RIFF, wrong WAVE identifier.
        file_buf.delete();
        put_le32(ID_RIFF);
        put_le32(32'd0);
        put_le32(ID_WAVE ^ 32'h8000_0000);
        emit_file();
      end

      queued = 0;
      while (queued < PHASE_BUDGET) begin
        if ($urandom_range(0, 6) == 0) begin
          // Noise, sometimes behind a valid RIFF identifier.
          file_buf.delete();
          if ($urandom_range(0, 1) == 1) put_le32(ID_RIFF);
          put_random($urandom_range(1, 20));
        end else begin
          build_wave_file();
        end
        queued += file_buf.size();
        emit_file();
      end

      // Drain before the next register writes.
      while (file_bytes_q.size() != 0 || byte_held || expected_results.size() != 0)
        @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
